>>> rtl/chash_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chash_pkg : shared types and constants for the chained hash table
// Field widths, operation and status codes, and the command/status
// structs passed between the controller and the datapath.
// ---------------------------------------------------------------------------
package chash_pkg;

    // Fixed field widths
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 64;
    localparam int OP_W   = 2;
    localparam int ST_W   = 3;
    localparam int CFG_W  = 5;
    localparam int APB_DW = 32;
    localparam int PADDR_W = 3;

    // Parameter defaults
    localparam int MAX_BUCKETS_DEF  = 16;
    localparam int BUCKET_DEPTH_DEF = 8;

    // Reset value of the bucket count register
    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(16);

    // Register index of bucket_count (paddr[2])
    localparam logic REG_BUCKET_COUNT = 1'b0;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_REMOVED   = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic            clear_step;  // clear one slot of the key store
        logic            load;        // capture item, start the modulo
        logic            div_step;    // one restoring division step
        logic            walk;        // walk the bucket slots
        logic            wr_key;      // write valid bit and key
        logic            key_valid;   // valid bit written with the key
        logic            wr_val;      // write the value store
        logic            use_free;    // target the free slot, else the hit
        logic            result;      // present the result
        logic [ST_W-1:0] status;      // status code of the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic            clear_last;  // clearing pass at its last slot
        logic            div_last;    // final division step
        logic            walk_done;   // key found or bucket fully scanned
        logic            match;       // key present in the bucket
        logic            free;        // bucket has a free slot
        logic [OP_W-1:0] op;          // operation of the current item
    } t_stat;

endpackage
`default_nettype wire

>>> rtl/chained_hash_table_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chained_hash_table_top : key-value table with separate chaining
// Command-style item port, APB-style register port holding bucket_count.
// ---------------------------------------------------------------------------
// Operation: after start is taken, a bit-serial modulo of the key, then a bucket
//   walk, one slot read per cycle, that stops on a hit, then an action state;
//   o_done is registered from the action state.
// Items: one at a time; busy is low again in the o_done cycle, and the earliest
//   next start is taken at the edge that ends the o_done cycle.
// Reset: synchronous; a clearing pass over all MAX_BUCKETS*BUCKET_DEPTH key slots
//   (128 by default) runs first with busy high. Results cannot be held off.
// ---------------------------------------------------------------------------
module chained_hash_table_top #(
    parameter int MAX_BUCKETS  = chash_pkg::MAX_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = chash_pkg::BUCKET_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item port
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [chash_pkg::OP_W-1:0]    i_operation,
    input  wire logic [chash_pkg::KEY_W-1:0]   i_key,
    input  wire logic [chash_pkg::VAL_W-1:0]   i_value,
    output logic                               o_done,
    output logic [chash_pkg::ST_W-1:0]         o_status,
    output logic [chash_pkg::VAL_W-1:0]        o_found_value,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [chash_pkg::PADDR_W-1:0] paddr,
    input  wire logic [chash_pkg::APB_DW-1:0]  pwdata,
    output logic [chash_pkg::APB_DW-1:0]       prdata,
    output logic                               pready
);
    import chash_pkg::*;

    logic [CFG_W-1:0] r_bucket_count;
    logic             w_cfg_wr;
    t_cmd             w_cmd;
    t_stat            w_stat;

    // Register write and readback
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RST;
        end else if (w_cfg_wr && (paddr[2] == REG_BUCKET_COUNT)) begin
            r_bucket_count <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? APB_DW'(r_bucket_count) : '0;

    // Sequencer
    chash_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Datapath
    chash_dp #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_bucket_count (r_bucket_count),
        .i_operation    (i_operation),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_found_value  (o_found_value)
    );

endmodule
`default_nettype wire

>>> rtl/chash_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chash_ctrl : sequencer of the chained hash table
// One-hot state machine: clearing pass after reset, then per item the
// modulo, the bucket walk and the action state.
// ---------------------------------------------------------------------------
module chash_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire chash_pkg::t_stat i_stat,
    output chash_pkg::t_cmd       o_cmd
);
    import chash_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_WALK  = 5'b01000,
        S_ACT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) n_state = S_ACT;
            end
            S_ACT: begin
                o_cmd.result = 1'b1;
                n_state      = S_IDLE;
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.match) begin
                            // key present: overwrite its value
                            o_cmd.wr_val = 1'b1;
                            o_cmd.status = ST_UPDATED;
                        end else if (i_stat.free) begin
                            // append in the lowest free slot
                            o_cmd.wr_key    = 1'b1;
                            o_cmd.key_valid = 1'b1;
                            o_cmd.wr_val    = 1'b1;
                            o_cmd.use_free  = 1'b1;
                            o_cmd.status    = ST_INSERTED;
                        end else begin
                            o_cmd.status = ST_FULL;
                        end
                    end
                    OP_SEARCH: begin
                        o_cmd.status = i_stat.match ? ST_FOUND : ST_NOT_FOUND;
                    end
                    OP_REMOVE: begin
                        if (i_stat.match) begin
                            o_cmd.wr_key = 1'b1;
                            o_cmd.status = ST_REMOVED;
                        end else begin
                            o_cmd.status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        o_cmd.status = ST_NOT_FOUND;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    // Checks
    a_act_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ACT |=> r_state == S_IDLE)
        else $error("action cycle not followed by idle");

    a_walk_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && $past(r_state) != S_WALK) |-> $past(r_state) == S_DIV)
        else $error("bucket walk entered without a finished modulo");

endmodule
`default_nettype wire

>>> rtl/chash_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chash_dp : datapath of the chained hash table
// Bit-serial key modulo, slot stores for keys and values, the bucket
// walk with its hit and free-slot trackers, and the result registers.
// ---------------------------------------------------------------------------
module chash_dp #(
    parameter int MAX_BUCKETS  = chash_pkg::MAX_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = chash_pkg::BUCKET_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire chash_pkg::t_cmd               i_cmd,
    output chash_pkg::t_stat                   o_stat,
    input  wire logic [chash_pkg::CFG_W-1:0]   i_bucket_count,
    input  wire logic [chash_pkg::OP_W-1:0]    i_operation,
    input  wire logic [chash_pkg::KEY_W-1:0]   i_key,
    input  wire logic [chash_pkg::VAL_W-1:0]   i_value,
    output logic                               o_done,
    output logic [chash_pkg::ST_W-1:0]         o_status,
    output logic [chash_pkg::VAL_W-1:0]        o_found_value
);
    import chash_pkg::*;

    localparam int TOTAL = MAX_BUCKETS * BUCKET_DEPTH;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int IW    = $clog2(BUCKET_DEPTH + 1);
    localparam int DCW   = $clog2(KEY_W);

    // Item registers
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;

    // Divider
    logic [KEY_W-1:0] r_dkey;
    logic [CFG_W-1:0] r_div;
    logic [CFG_W-1:0] r_rem;
    logic [DCW-1:0]   r_div_cnt;
    logic [CFG_W-1:0] w_divisor;
    logic [CFG_W:0]   w_trial;

    // Walk
    logic [IW-1:0]    r_idx;
    logic             r_cmp_en;
    logic             r_cmp_last;
    logic [AW-1:0]    r_cmp_slot;
    logic             r_match;
    logic [AW-1:0]    r_match_slot;
    logic [VAL_W-1:0] r_match_val;
    logic             r_free;
    logic [AW-1:0]    r_free_slot;
    logic [BW-1:0]    w_bucket;
    logic [AW-1:0]    w_base;
    logic [AW-1:0]    w_rd_addr;
    logic             w_hit;
    logic             w_issue;

    // Stores: key store carries the valid bit on top
    logic [KEY_W:0]   r_key_mem [TOTAL];
    logic [VAL_W-1:0] r_val_mem [TOTAL];
    logic [KEY_W:0]   r_key_rd;
    logic [VAL_W-1:0] r_val_rd;
    logic [AW-1:0]    r_clr_addr;
    logic [AW-1:0]    w_wr_addr;
    logic             w_key_we;
    logic [KEY_W:0]   w_key_wd;

    // Result registers
    logic             r_done;
    logic [ST_W-1:0]  r_status;
    logic [VAL_W-1:0] r_found_value;

    // Buckets in use: zero means one, saturate at MAX_BUCKETS
    always_comb begin
        if (i_bucket_count == '0) begin
            w_divisor = CFG_W'(1);
        end else if (int'(i_bucket_count) > MAX_BUCKETS) begin
            w_divisor = CFG_W'(MAX_BUCKETS);
        end else begin
            w_divisor = i_bucket_count;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_key   <= i_key;
            r_value <= i_value;
            r_div   <= w_divisor;
        end
    end

    // Restoring modulo, one key bit per cycle
    assign w_trial = {r_rem, r_dkey[KEY_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.load) begin
            r_div_cnt <= '0;
            r_dkey    <= i_key;
            r_rem     <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 1'b1;
            r_dkey    <= {r_dkey[KEY_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= CFG_W'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= CFG_W'(w_trial);
            end
        end
    end

    // Slot address of the walk
    assign w_bucket  = BW'(r_rem);
    assign w_base    = AW'(w_bucket * BUCKET_DEPTH);
    assign w_rd_addr = w_base + AW'(r_idx);
    assign w_issue   = i_cmd.walk && (r_idx < IW'(BUCKET_DEPTH));
    assign w_hit     = r_cmp_en && r_key_rd[KEY_W] && (r_key_rd[KEY_W-1:0] == r_key);

    // Walk: issue one slot read per cycle, compare it the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_cmp_en <= 1'b0;
            r_match  <= 1'b0;
            r_free   <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx    <= '0;
            r_cmp_en <= 1'b0;
            r_match  <= 1'b0;
            r_free   <= 1'b0;
        end else if (i_cmd.walk) begin
            r_cmp_en   <= w_issue;
            r_cmp_last <= (r_idx == IW'(BUCKET_DEPTH - 1));
            r_cmp_slot <= w_rd_addr;
            if (w_issue) r_idx <= r_idx + 1'b1;
            if (w_hit) begin
                r_match      <= 1'b1;
                r_match_slot <= r_cmp_slot;
                r_match_val  <= r_val_rd;
            end
            // lowest free slot only
            if (r_cmp_en && !r_key_rd[KEY_W] && !r_free) begin
                r_free      <= 1'b1;
                r_free_slot <= r_cmp_slot;
            end
        end
    end

    // Clearing pass over the key store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Store write port
    assign w_wr_addr = i_cmd.clear_step ? r_clr_addr
                     : (i_cmd.use_free ? r_free_slot : r_match_slot);
    assign w_key_we  = i_cmd.clear_step || i_cmd.wr_key;
    assign w_key_wd  = i_cmd.clear_step ? '0 : {i_cmd.key_valid, r_key};

    always_ff @(posedge i_clk) begin
        if (w_key_we) r_key_mem[w_wr_addr] <= w_key_wd;
        if (i_cmd.wr_val) r_val_mem[w_wr_addr] <= r_value;
    end

    // Store read port, registered
    always_ff @(posedge i_clk) begin
        r_key_rd <= r_key_mem[w_rd_addr];
        r_val_rd <= r_val_mem[w_rd_addr];
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_status      <= i_cmd.status;
            r_found_value <= (i_cmd.status == ST_FOUND) ? r_match_val : '0;
        end
    end

    // Status back to the controller
    assign o_stat.clear_last = (r_clr_addr == AW'(TOTAL - 1));
    assign o_stat.div_last   = (r_div_cnt == DCW'(KEY_W - 1));
    assign o_stat.walk_done  = r_cmp_en && (w_hit || r_cmp_last);
    assign o_stat.match      = r_match;
    assign o_stat.free       = r_free;
    assign o_stat.op         = r_op;

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_value = r_found_value;

    // Checks
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for more than one cycle");

    a_value_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status != ST_FOUND) |-> r_found_value == '0)
        else $error("found value non-zero without a hit");

    a_append_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_key && i_cmd.key_valid) |-> (r_free && !r_match))
        else $error("append without a free slot or with the key present");

endmodule
`default_nettype wire
